>>> rtl/core/mrod_pkg.sv
// shared types and constants for the mixed radix offset decomposer
package mrod_pkg;

   localparam int DIGIT_COUNT     = 4;
   localparam int VAR_IDX_WIDTH   = 2;
   localparam int VAR_COUNT_WIDTH = 3;
   localparam int CSR_IDX_WIDTH   = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_VAR_COUNT = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIX_0   = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIX_1   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIX_2   = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RADIX_3   = 3'd4;

   localparam logic [VAR_COUNT_WIDTH-1:0] VAR_COUNT_RESET = 3'd4;

   typedef struct packed {
      logic                     load;
      logic                     div_step;
      logic                     digit_store;
      logic [VAR_IDX_WIDTH-1:0] var_idx;
      logic                     result_load;
   } cmd_type;

   typedef struct packed {
      logic [VAR_COUNT_WIDTH-1:0] active_count;
   } status_type;

endpackage

>>> rtl/core/mrod_ctrl.sv
// sequencer for the item handshake, the digit loop and the divider bit steps
module mrod_ctrl
   import mrod_pkg::*;
#(
   parameter int OFFSET_WIDTH = 31
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int BIT_CNT_WIDTH = $clog2(OFFSET_WIDTH);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_STORE  = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [BIT_CNT_WIDTH-1:0] bit_cnt_ff, bit_cnt_in;
   logic [VAR_IDX_WIDTH-1:0] var_idx_ff, var_idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     accept;
   logic                     last_var;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign last_var  = (({1'b0, var_idx_ff} + VAR_COUNT_WIDTH'(1)) == status.active_count);

   always_comb begin
      state_in         = state_ff;
      bit_cnt_in       = bit_cnt_ff;
      var_idx_in       = var_idx_ff;
      cmd              = '0;
      cmd.var_idx      = var_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load   = 1'b1;
               var_idx_in = '0;
               bit_cnt_in = '0;
               // no active variables: the whole offset is the high part
               state_in   = (status.active_count == '0) ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            bit_cnt_in   = bit_cnt_ff + BIT_CNT_WIDTH'(1);
            if (bit_cnt_ff == BIT_CNT_WIDTH'(OFFSET_WIDTH - 1)) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.digit_store = 1'b1;
            bit_cnt_in      = '0;
            if (last_var) begin
               state_in = ST_DONE;
            end else begin
               var_idx_in = var_idx_ff + VAR_IDX_WIDTH'(1);
               state_in   = ST_DIVIDE;
            end
         end
         ST_DONE: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.result_load = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.result_load || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         var_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         var_idx_ff   <= var_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> rtl/core/mrod_datapath.sv
// config registers, bit-serial restoring divider, digit store and output register
module mrod_datapath
   import mrod_pkg::*;
#(
   parameter int MAX_VARS     = 4,
   parameter int RADIX_WIDTH  = 16,
   parameter int OFFSET_WIDTH = 31,
   parameter int CSR_WIDTH    = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   input  logic [OFFSET_WIDTH-1:0]  req_flat_offset,
   input  cmd_type                  cmd,
   output status_type               status,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_0,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_1,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_2,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_3,
   output logic                     rsp_wrapped
);

   localparam int VAR_LIMIT = (MAX_VARS < DIGIT_COUNT) ? MAX_VARS : DIGIT_COUNT;

   logic [VAR_COUNT_WIDTH-1:0] var_count_ff;
   logic [RADIX_WIDTH-1:0]     radix_ff [DIGIT_COUNT];

   logic [OFFSET_WIDTH-1:0]    quo_ff, quo_in;
   logic [RADIX_WIDTH:0]       rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0]     digit_ff [DIGIT_COUNT];
   logic [RADIX_WIDTH-1:0]     out_digit_ff [DIGIT_COUNT];
   logic                       out_wrapped_ff;

   logic [RADIX_WIDTH-1:0]     radix_sel;
   logic [RADIX_WIDTH:0]       divisor;
   logic [RADIX_WIDTH+1:0]     shifted;
   logic [RADIX_WIDTH+1:0]     diff;
   logic                       fits;

   // config writes, indexes beyond the radix registers are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         var_count_ff <= VAR_COUNT_RESET;
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            radix_ff[i] <= RADIX_WIDTH'(2);
         end
      end else if (csr_valid) begin
         case (csr_index)
            CSR_VAR_COUNT: var_count_ff <= csr_wdata[VAR_COUNT_WIDTH-1:0];
            CSR_RADIX_0:   radix_ff[0]  <= csr_wdata[RADIX_WIDTH-1:0];
            CSR_RADIX_1:   radix_ff[1]  <= csr_wdata[RADIX_WIDTH-1:0];
            CSR_RADIX_2:   radix_ff[2]  <= csr_wdata[RADIX_WIDTH-1:0];
            CSR_RADIX_3:   radix_ff[3]  <= csr_wdata[RADIX_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (var_count_ff > VAR_COUNT_WIDTH'(VAR_LIMIT)) begin
         status.active_count = VAR_COUNT_WIDTH'(VAR_LIMIT);
      end else begin
         status.active_count = var_count_ff;
      end
   end

   // a zero radix means the full register range, 2^RADIX_WIDTH
   assign radix_sel = radix_ff[cmd.var_idx];
   assign divisor   = {(radix_sel == '0), radix_sel};
   assign shifted   = {rem_ff, quo_ff[OFFSET_WIDTH-1]};
   assign diff      = shifted - {1'b0, divisor};
   assign fits      = !diff[RADIX_WIDTH+1];

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      if (cmd.load) begin
         quo_in = req_flat_offset;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[OFFSET_WIDTH-2:0], fits};
         rem_in = fits ? diff[RADIX_WIDTH:0] : shifted[RADIX_WIDTH:0];
      end else if (cmd.digit_store) begin
         rem_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (cmd.load) begin
            digit_ff[i] <= '0;
         end else if (cmd.digit_store && (cmd.var_idx == VAR_IDX_WIDTH'(i))) begin
            digit_ff[i] <= rem_ff[RADIX_WIDTH-1:0];
         end
      end
      if (cmd.result_load) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            out_digit_ff[i] <= digit_ff[i];
         end
         // whatever quotient is left is the dropped high part
         out_wrapped_ff <= (quo_ff != '0);
      end
   end

   assign rsp_digit_0 = out_digit_ff[0];
   assign rsp_digit_1 = out_digit_ff[1];
   assign rsp_digit_2 = out_digit_ff[2];
   assign rsp_digit_3 = out_digit_ff[3];
   assign rsp_wrapped = out_wrapped_ff;

endmodule

>>> rtl/core/mixed_radix_offset_decompose.sv
// Mixed radix offset decomposer: splits flat_offset into up to four digits, variable 0 least
// significant, with a zero radix meaning 2^RADIX_WIDTH and wrapped set when a high part is
// left over. One item is in work at a time: each active variable takes one pass of the shared
// bit-serial restoring divider and a digit store, between the accept and the result load;
// with no active variables the accept goes straight on to the result load.
// The next item is taken while a finished result still waits in the output register.
// Config writes are always ready and must be made only while the block is idle.
module mixed_radix_offset_decompose
   import mrod_pkg::*;
#(
   parameter  int MAX_VARS     = 4,
   parameter  int RADIX_WIDTH  = 16,
   parameter  int OFFSET_WIDTH = 31,
   localparam int CSR_WIDTH    = (RADIX_WIDTH > VAR_COUNT_WIDTH) ? RADIX_WIDTH : VAR_COUNT_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [OFFSET_WIDTH-1:0]  req_flat_offset,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_0,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_1,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_2,
   output logic [RADIX_WIDTH-1:0]   rsp_digit_3,
   output logic                     rsp_wrapped
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mrod_ctrl #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mrod_datapath #(
      .MAX_VARS     (MAX_VARS),
      .RADIX_WIDTH  (RADIX_WIDTH),
      .OFFSET_WIDTH (OFFSET_WIDTH),
      .CSR_WIDTH    (CSR_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_flat_offset (req_flat_offset),
      .cmd             (cmd),
      .status          (status),
      .rsp_digit_0     (rsp_digit_0),
      .rsp_digit_1     (rsp_digit_1),
      .rsp_digit_2     (rsp_digit_2),
      .rsp_digit_3     (rsp_digit_3),
      .rsp_wrapped     (rsp_wrapped)
   );

endmodule

>>> rtl/core/mrod_checker.sv
// port-level checks for the mixed radix offset decomposer, bound to the top level
module mrod_checker #(
   parameter int RADIX_WIDTH  = 16
) (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [RADIX_WIDTH-1:0]   rsp_digit_0,
   input logic [RADIX_WIDTH-1:0]   rsp_digit_1,
   input logic [RADIX_WIDTH-1:0]   rsp_digit_2,
   input logic [RADIX_WIDTH-1:0]   rsp_digit_3,
   input logic                     rsp_wrapped
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_digit_0) && $stable(rsp_digit_1)
         && $stable(rsp_digit_2) && $stable(rsp_digit_3) && $stable(rsp_wrapped))
      else $error("stalled result item changed");

   // one item in work at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken again right after an item was accepted");

   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result item shown in the cycle after accept");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind mixed_radix_offset_decompose mrod_checker #(
   .RADIX_WIDTH  (RADIX_WIDTH)
) u_mrod_checker (.*);

>>> verif/mixed_radix_offset_decompose_tb.sv
// testbench for the mixed radix offset decomposer: digit prediction, stimulus and checks
`timescale 1ns / 1ps

typedef struct packed {
   logic [3:0][15:0] digit;
   logic             wrapped;
} digit_set_type;

class offset_digit_book;
   logic [2:0]     var_count;
   logic [15:0]    radix [4];
   digit_set_type  pending_digits [$];
   int             errors;

   function new();
      var_count = mrod_pkg::VAR_COUNT_RESET;
      foreach (radix[i]) radix[i] = 16'd2;
      errors = 0;
   endfunction

   function void set_register(logic [2:0] idx, logic [15:0] data);
      case (idx)
         mrod_pkg::CSR_VAR_COUNT: var_count = data[2:0];
         mrod_pkg::CSR_RADIX_0:   radix[0] = data;
         mrod_pkg::CSR_RADIX_1:   radix[1] = data;
         mrod_pkg::CSR_RADIX_2:   radix[2] = data;
         mrod_pkg::CSR_RADIX_3:   radix[3] = data;
         default: ;
      endcase
   endfunction

   // counts above the number of radix registers saturate
   function int active_count();
      return (var_count > 3'd4) ? 4 : int'(var_count);
   endfunction

   function digit_set_type split_offset(logic [30:0] offset);
      digit_set_type d;
      logic [31:0]   rest;
      logic [16:0]   r;
      int            i;
      d    = '0;
      rest = {1'b0, offset};
      for (i = 0; i < active_count(); i++) begin
         // a zero register stands for the full 2^16 range
         r          = (radix[i] == 16'd0) ? 17'h10000 : {1'b0, radix[i]};
         d.digit[i] = 16'(rest % r);
         rest       = rest / r;
      end
      d.wrapped = (rest != 32'd0);
      return d;
   endfunction

   function void note_offset(logic [30:0] offset);
      pending_digits.insert(pending_digits.size(), split_offset(offset));
   endfunction

   function void check_digits(digit_set_type seen);
      digit_set_type want;
      int            i;
      if (pending_digits.size() == 0) begin
         $error("result with no item outstanding: digits %h wrapped %0d",
                seen.digit, seen.wrapped);
         errors++;
         return;
      end
      want = pending_digits.pop_front();
      for (i = 0; i < 4; i++) begin
         if (seen.digit[i] !== want.digit[i]) begin
            $error("digit_%0d expected %0d got %0d", i, want.digit[i], seen.digit[i]);
            errors++;
         end
      end
      if (seen.wrapped !== want.wrapped) begin
         $error("wrapped expected %0d got %0d", want.wrapped, seen.wrapped);
         errors++;
      end
   endfunction
endclass

module mixed_radix_offset_decompose_tb;
   import mrod_pkg::*;

   localparam int                HOLD_CYCLES     = 800;
   localparam int                TAIL_CYCLES     = 300;
   localparam int                RANDOM_PHASES   = 8;
   localparam int                ITEMS_PER_PHASE = 50;
   localparam int                PRESSURE_PHASE  = 3;
   localparam logic [30:0]       OFFSET_MAX      = 31'h7FFF_FFFF;

   logic                     clock;
   logic                     reset;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index;
   logic [15:0]              csr_wdata;
   logic                     req_valid;
   logic                     req_ready;
   logic [30:0]              req_flat_offset;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [15:0]              rsp_digit_0;
   logic [15:0]              rsp_digit_1;
   logic [15:0]              rsp_digit_2;
   logic [15:0]              rsp_digit_3;
   logic                     rsp_wrapped;

   offset_digit_book book;
   bit               gaps_on      = 1'b1;
   bit               hold_pending = 1'b0;

   mixed_radix_offset_decompose #(
      .MAX_VARS     (4),
      .RADIX_WIDTH  (16),
      .OFFSET_WIDTH (31)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_flat_offset (req_flat_offset),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digit_0     (rsp_digit_0),
      .rsp_digit_1     (rsp_digit_1),
      .rsp_digit_2     (rsp_digit_2),
      .rsp_digit_3     (rsp_digit_3),
      .rsp_wrapped     (rsp_wrapped)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // mostly short, now and then long
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [15:0] pick_radix();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       return 16'd0;
         1:       return 16'd1;
         2:       return 16'hFFFF;
         3, 4, 5, 6: return 16'($urandom_range(2, 20));
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // offsets spread over the whole field, below the table size and around its edge
   function automatic logic [30:0] pick_offset();
      longint unsigned prod;
      longint unsigned cand;
      logic [31:0]     w;
      int              i;
      int              sel;
      prod = 1;
      for (i = 0; i < book.active_count(); i++) begin
         prod = prod * ((book.radix[i] == 16'd0) ? 64'd65536 : 64'(book.radix[i]));
         if (prod > 64'h1_0000_0000) prod = 64'h1_0000_0000;
      end
      w   = $urandom;
      sel = $urandom_range(0, 9);
      if (sel < 4) return w[30:0];
      if (sel < 7) begin
         cand = (prod > 64'(OFFSET_MAX)) ? 64'(OFFSET_MAX) : prod;
         return 31'($urandom_range(0, 32'(cand)));
      end
      if (sel < 9) begin
         cand = prod - 1 + 64'($urandom_range(0, 2));
         if (cand > 64'(OFFSET_MAX)) cand = 64'(OFFSET_MAX);
         return cand[30:0];
      end
      return w[0] ? OFFSET_MAX : 31'd0;
   endfunction

   task automatic send_offset(input logic [30:0] offset);
      int gap;
      gap = (gaps_on && $urandom_range(0, 1) == 1) ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_flat_offset <= offset;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering and wait for every outstanding result
   task automatic settle();
      req_valid <= 1'b0;
      while (book.pending_digits.size() != 0) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_WIDTH-1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic configure(input logic [2:0] vc, input logic [15:0] r0,
                            input logic [15:0] r1, input logic [15:0] r2,
                            input logic [15:0] r3, input bit touch_unused);
      int k;
      settle();
      // upper data bits are don't-care for the count register
      write_reg(CSR_VAR_COUNT, {13'($urandom), vc});
      write_reg(CSR_RADIX_0, r0);
      write_reg(CSR_RADIX_1, r1);
      write_reg(CSR_RADIX_2, r2);
      write_reg(CSR_RADIX_3, r3);
      if (touch_unused) begin
         for (k = int'(CSR_RADIX_3) + 1; k < (1 << CSR_IDX_WIDTH); k++)
            write_reg(CSR_IDX_WIDTH'(k), 16'($urandom));
      end
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin : watch
      digit_set_type seen;
      if (!reset) begin
         if (csr_valid && csr_ready) book.set_register(csr_index, csr_wdata);
         if (req_valid && req_ready) book.note_offset(req_flat_offset);
         if (rsp_valid && rsp_ready) begin
            seen.digit   = {rsp_digit_3, rsp_digit_2, rsp_digit_1, rsp_digit_0};
            seen.wrapped = rsp_wrapped;
            book.check_digits(seen);
         end
      end
   end

   // receiver: random back-pressure plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            stall_left   = HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(0, 3) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left = pick_gap();
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int phase;
      int n;
      book            = new();
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_flat_offset = '0;
      csr_valid       = 1'b0;
      csr_index       = CSR_VAR_COUNT;
      csr_wdata       = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: four binary digits, table of 16
      send_offset(31'd0);
      send_offset(31'd15);
      send_offset(31'd16);
      send_offset(31'd17);
      send_offset(OFFSET_MAX);
      send_offset(31'h4000_0000);
      send_offset(31'h5555_5555);
      send_offset(31'h2AAA_AAAA);

      // no active variables
      configure(3'd0, 16'd5, 16'd5, 16'd5, 16'd5, 1'b0);
      send_offset(31'd0);
      send_offset(31'd1);
      send_offset(OFFSET_MAX);

      // oversized count, every radix at full range
      configure(3'd7, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      send_offset(OFFSET_MAX);
      send_offset(31'h1234_5678);
      send_offset(31'h0001_0000);

      // radix of one everywhere
      configure(3'd4, 16'd1, 16'd1, 16'd1, 16'd1, 1'b0);
      send_offset(31'd0);
      send_offset(31'd5);
      send_offset(OFFSET_MAX);

      // largest radices
      configure(3'd4, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
      send_offset(OFFSET_MAX);
      send_offset(31'd65534);
      send_offset(31'd65535);

      // two active variables, mixed radices, unused register indexes written
      configure(3'd2, 16'd1, 16'd0, 16'd3, 16'd7, 1'b1);
      send_offset(31'h0000_FFFF);
      send_offset(31'h0001_0000);
      send_offset(OFFSET_MAX);

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         n = $urandom_range(0, 19);
         configure((n < 2) ? 3'd0 : (n < 5) ? 3'($urandom_range(5, 7)) :
                   3'($urandom_range(1, 4)),
                   pick_radix(), pick_radix(), pick_radix(), pick_radix(), 1'b0);
         gaps_on = (phase % 3 != 2) && (phase != PRESSURE_PHASE);
         // sender keeps offering back to back while the receiver holds off
         if (phase == PRESSURE_PHASE) hold_pending = 1'b1;
         for (n = 0; n < ITEMS_PER_PHASE; n++) send_offset(pick_offset());
      end

      settle();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (book.pending_digits.size() != 0) begin
         $error("%0d results never arrived", book.pending_digits.size());
         book.errors++;
      end
      if (book.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
